@@ design/str_pkg.sv @@
// ---------------------------------------------------------------------------
// str_pkg
// Shared types, register indexes, reset values and small helper functions
// for the trapezoidal step-rate ramp generator.
// ---------------------------------------------------------------------------
package str_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_PERIOD       = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PERIOD       = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEPS_PER_CHANGE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DISTANCE_SCALE   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEGREE_SCALE     = 3'd4;

	// field widths
	localparam int unsigned PERIOD_BITS = 8;
	localparam int unsigned SCALE_BITS  = 24;
	localparam int unsigned AMOUNT_BITS = 16;
	localparam int unsigned RAMP_BITS   = 2 * PERIOD_BITS;
	localparam int unsigned FRAC_BITS   = 16;
	localparam int unsigned PROD_BITS   = AMOUNT_BITS + SCALE_BITS;
	// rounded product shifted down, one carry bit kept
	localparam int unsigned TGT_BITS    = PROD_BITS - FRAC_BITS + 1;

	// reset values of the configuration registers
	localparam logic [PERIOD_BITS-1:0] RST_MIN_PERIOD       = 8'd36;
	localparam logic [PERIOD_BITS-1:0] RST_MAX_PERIOD       = 8'd120;
	localparam logic [PERIOD_BITS-1:0] RST_STEPS_PER_CHANGE = 8'd10;
	localparam logic [SCALE_BITS-1:0]  RST_DISTANCE_SCALE   = 24'd12206532;
	localparam logic [SCALE_BITS-1:0]  RST_DEGREE_SCALE     = 24'd2023918;
	localparam logic [RAMP_BITS-1:0]   RST_RAMP             =
		RAMP_BITS'(10 * (120 - 36));

	// move kinds and request types
	localparam logic [1:0] KIND_FORWARD  = 2'd0;
	localparam logic [1:0] KIND_BACKWARD = 2'd1;
	localparam logic [1:0] KIND_LEFT     = 2'd2;
	localparam logic [1:0] KIND_RIGHT    = 2'd3;
	localparam logic       REQ_TICK      = 1'b0;
	localparam logic       REQ_START     = 1'b1;

	// ramp phase codes as shown on the result beat
	localparam logic [1:0] RAMP_ACCEL = 2'd0;
	localparam logic [1:0] RAMP_CONST = 2'd1;
	localparam logic [1:0] RAMP_DECEL = 2'd2;

	// internal phase state, one-hot
	typedef enum logic [2:0] {
		PH_ACCEL = 3'b001,
		PH_CONST = 3'b010,
		PH_DECEL = 3'b100
	} phase_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic [PERIOD_BITS-1:0] min_period;
		logic [PERIOD_BITS-1:0] max_period;
		logic [PERIOD_BITS-1:0] steps_per_change;
		logic [SCALE_BITS-1:0]  distance_scale;
		logic [SCALE_BITS-1:0]  degree_scale;
		logic [RAMP_BITS-1:0]   ramp;
	} cfg_t;

	// one result beat
	typedef struct packed {
		logic                   step_strobe;
		logic                   right_dir;
		logic                   left_dir;
		logic                   driver_awake;
		logic                   move_done;
		logic [1:0]             ramp_phase;
		logic [PERIOD_BITS-1:0] step_period;
	} rsp_t;

	// direction bits per move kind: bit 0 right, bit 1 left
	function automatic logic [1:0] dir_of(logic [1:0] kind);
		logic [1:0] d;
		case (kind)
			KIND_FORWARD:  d = 2'b00;
			KIND_BACKWARD: d = 2'b11;
			KIND_LEFT:     d = 2'b10;
			KIND_RIGHT:    d = 2'b01;
			default:       d = 2'b00;
		endcase
		return d;
	endfunction

	// phase state to result code
	function automatic logic [1:0] phase_code(phase_t ph);
		logic [1:0] c;
		case (ph)
			PH_ACCEL: c = RAMP_ACCEL;
			PH_CONST: c = RAMP_CONST;
			PH_DECEL: c = RAMP_DECEL;
			default:  c = RAMP_ACCEL;
		endcase
		return c;
	endfunction

endpackage

@@ design/str_req_if.sv @@
// ---------------------------------------------------------------------------
// str_req_if
// Request channel: timer ticks and move starts.
// ---------------------------------------------------------------------------
interface str_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [1:0]  move_kind;
	logic [15:0] amount;

	modport source(output valid, req_type, move_kind, amount, input ready);
	modport sink(input valid, req_type, move_kind, amount, output ready);
endinterface

@@ design/str_rsp_if.sv @@
// ---------------------------------------------------------------------------
// str_rsp_if
// Result channel: one beat per request beat.
// ---------------------------------------------------------------------------
interface str_rsp_if;
	logic       valid;
	logic       ready;
	logic       step_strobe;
	logic       right_dir;
	logic       left_dir;
	logic       driver_awake;
	logic       move_done;
	logic [1:0] ramp_phase;
	logic [7:0] step_period;

	modport source(output valid, step_strobe, right_dir, left_dir, driver_awake,
		move_done, ramp_phase, step_period, input ready);
	modport sink(input valid, step_strobe, right_dir, left_dir, driver_awake,
		move_done, ramp_phase, step_period, output ready);
endinterface

@@ design/str_cfg_if.sv @@
// ---------------------------------------------------------------------------
// str_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface str_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ design/str_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// str_cfg_regs
// Configuration register file with a registered ramp length
// steps_per_change * (max_period - min_period).
// ---------------------------------------------------------------------------
module str_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	str_cfg_if.sink              cfg,
	output str_pkg::cfg_t        cfg_out
);

	logic [str_pkg::PERIOD_BITS-1:0] min_period_q;
	logic [str_pkg::PERIOD_BITS-1:0] max_period_q;
	logic [str_pkg::PERIOD_BITS-1:0] spc_q;
	logic [str_pkg::SCALE_BITS-1:0]  dist_scale_q;
	logic [str_pkg::SCALE_BITS-1:0]  deg_scale_q;
	logic [str_pkg::RAMP_BITS-1:0]   ramp_q;
	logic [str_pkg::PERIOD_BITS-1:0] diff;

	// writes are always taken
	assign cfg.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q <= str_pkg::RST_MIN_PERIOD;
			max_period_q <= str_pkg::RST_MAX_PERIOD;
			spc_q        <= str_pkg::RST_STEPS_PER_CHANGE;
			dist_scale_q <= str_pkg::RST_DISTANCE_SCALE;
			deg_scale_q  <= str_pkg::RST_DEGREE_SCALE;
		end else if (cfg.valid) begin
			case (cfg.index)
				str_pkg::REG_MIN_PERIOD:
					min_period_q <= cfg.data[str_pkg::PERIOD_BITS-1:0];
				str_pkg::REG_MAX_PERIOD:
					max_period_q <= cfg.data[str_pkg::PERIOD_BITS-1:0];
				str_pkg::REG_STEPS_PER_CHANGE:
					spc_q <= cfg.data[str_pkg::PERIOD_BITS-1:0];
				str_pkg::REG_DISTANCE_SCALE:
					dist_scale_q <= cfg.data;
				str_pkg::REG_DEGREE_SCALE:
					deg_scale_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// ramp length, negative span counts as zero
	assign diff = (max_period_q > min_period_q) ? (max_period_q - min_period_q)
		: '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q <= str_pkg::RST_RAMP;
		end else begin
			ramp_q <= str_pkg::RAMP_BITS'(spc_q) * str_pkg::RAMP_BITS'(diff);
		end
	end

	assign cfg_out.min_period       = min_period_q;
	assign cfg_out.max_period       = max_period_q;
	assign cfg_out.steps_per_change = spc_q;
	assign cfg_out.distance_scale   = dist_scale_q;
	assign cfg_out.degree_scale     = deg_scale_q;
	assign cfg_out.ramp             = ramp_q;

endmodule

@@ design/str_target.sv @@
// ---------------------------------------------------------------------------
// str_target
// Step target of a move start: amount times the Q8.16 scale, rounded half
// up and saturated to the step counter width.
// ---------------------------------------------------------------------------
module str_target #(
	parameter int unsigned STEP_COUNT_BITS = 24
) (
	input  logic [1:0]                         move_kind,
	input  logic [str_pkg::AMOUNT_BITS-1:0]    amount,
	input  str_pkg::cfg_t                      cfg,
	output logic [STEP_COUNT_BITS-1:0]         target
);

	localparam int unsigned EXT_BITS = (STEP_COUNT_BITS > str_pkg::TGT_BITS) ?
		STEP_COUNT_BITS : str_pkg::TGT_BITS;

	logic [str_pkg::SCALE_BITS-1:0] scale;
	logic [str_pkg::PROD_BITS:0]    rounded;
	logic [str_pkg::TGT_BITS-1:0]   t;
	logic [EXT_BITS-1:0]            t_ext;
	logic [EXT_BITS-1:0]            limit;

	// distance scale for straight moves, degree scale for turns
	assign scale = (move_kind == str_pkg::KIND_FORWARD ||
		move_kind == str_pkg::KIND_BACKWARD) ? cfg.distance_scale
		: cfg.degree_scale;

	// multiply and round
	assign rounded = (str_pkg::PROD_BITS+1)'(amount) * (str_pkg::PROD_BITS+1)'(scale)
		+ (str_pkg::PROD_BITS+1)'(1 << (str_pkg::FRAC_BITS - 1));
	assign t = rounded[str_pkg::PROD_BITS:str_pkg::FRAC_BITS];

	// saturate at the counter range
	assign t_ext  = EXT_BITS'(t);
	assign limit  = EXT_BITS'({STEP_COUNT_BITS{1'b1}});
	assign target = (t_ext > limit) ? {STEP_COUNT_BITS{1'b1}}
		: t_ext[STEP_COUNT_BITS-1:0];

endmodule

@@ design/str_core.sv @@
// ---------------------------------------------------------------------------
// str_core
// Motion state and the single-pass update for one request beat: move start,
// compare timer, step counting and the accelerate, constant, decelerate ramp.
// ---------------------------------------------------------------------------
module str_core #(
	parameter int unsigned STEP_COUNT_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic                         req_type,
	input  logic [1:0]                   move_kind,
	input  logic [STEP_COUNT_BITS-1:0]   target_in,
	input  str_pkg::cfg_t                cfg,
	output str_pkg::rsp_t                result
);

	localparam int unsigned PB = str_pkg::PERIOD_BITS;

	logic [STEP_COUNT_BITS-1:0] step_count_q, step_count_d;
	logic [STEP_COUNT_BITS-1:0] target_q, target_d;
	logic [PB-1:0]              spacing_q, spacing_d;
	str_pkg::phase_t            phase_q, phase_d;
	logic [PB-1:0]              period_q, period_d;
	logic [PB-1:0]              tick_q, tick_d;
	logic                       running_q, running_d;
	logic                       done_q, done_d;
	logic [1:0]                 dir_q, dir_d;
	logic                       awake_q, awake_d;
	logic                       pulse;
	logic                       change;
	logic [STEP_COUNT_BITS-1:0] ramp_ext;
	logic [STEP_COUNT_BITS-1:0] point;

	// deceleration point, clamped at zero
	assign ramp_ext = STEP_COUNT_BITS'(cfg.ramp);
	assign point    = (target_q > ramp_ext) ? (target_q - ramp_ext) : '0;

	// next state for the beat in the stage register
	always_comb begin
		step_count_d = step_count_q;
		target_d     = target_q;
		spacing_d    = spacing_q;
		phase_d      = phase_q;
		period_d     = period_q;
		tick_d       = tick_q;
		running_d    = running_q;
		done_d       = done_q;
		dir_d        = dir_q;
		awake_d      = awake_q;
		pulse        = 1'b0;
		change       = 1'b0;
		if (req_type == str_pkg::REQ_START) begin
			done_d    = 1'b0;
			awake_d   = 1'b1;
			dir_d     = str_pkg::dir_of(move_kind);
			target_d  = target_in;
			running_d = 1'b1;
		end else if (tick_q >= period_q) begin
			tick_d = '0;
			if (running_q) begin
				pulse        = 1'b1;
				step_count_d = step_count_q + STEP_COUNT_BITS'(1);
				spacing_d    = spacing_q + PB'(1);
				if (spacing_d >= cfg.steps_per_change) begin
					spacing_d = '0;
					change    = 1'b1;
				end
				case (phase_q)
					str_pkg::PH_ACCEL: begin
						if (change && period_q > cfg.min_period) begin
							period_d = period_q - PB'(1);
						end else if (period_q <= cfg.min_period) begin
							phase_d = str_pkg::PH_CONST;
						end
					end
					str_pkg::PH_CONST: begin
						if (step_count_d >= point) begin
							phase_d = str_pkg::PH_DECEL;
						end
					end
					str_pkg::PH_DECEL: begin
						if (change && period_q < cfg.max_period) begin
							period_d = period_q + PB'(1);
						end else if (period_q >= cfg.max_period) begin
							running_d    = 1'b0;
							awake_d      = 1'b0;
							step_count_d = '0;
							target_d     = '0;
							spacing_d    = '0;
							phase_d      = str_pkg::PH_ACCEL;
							done_d       = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end else begin
			tick_d = tick_q + PB'(1);
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= '0;
			target_q     <= '0;
			spacing_q    <= '0;
			phase_q      <= str_pkg::PH_ACCEL;
			period_q     <= str_pkg::RST_MAX_PERIOD;
			tick_q       <= '0;
			running_q    <= 1'b0;
			done_q       <= 1'b0;
			dir_q        <= 2'b00;
			awake_q      <= 1'b0;
		end else if (fire) begin
			step_count_q <= step_count_d;
			target_q     <= target_d;
			spacing_q    <= spacing_d;
			phase_q      <= phase_d;
			period_q     <= period_d;
			tick_q       <= tick_d;
			running_q    <= running_d;
			done_q       <= done_d;
			dir_q        <= dir_d;
			awake_q      <= awake_d;
		end
	end

	// result shows the state after the beat
	assign result.step_strobe  = pulse;
	assign result.right_dir    = dir_d[0];
	assign result.left_dir     = dir_d[1];
	assign result.driver_awake = awake_d;
	assign result.move_done    = done_d;
	assign result.ramp_phase   = str_pkg::phase_code(phase_d);
	assign result.step_period  = period_d;

endmodule

@@ design/stepper_trapezoid_ramp.sv @@
// ---------------------------------------------------------------------------
// stepper_trapezoid_ramp
// Trapezoidal step-rate ramp generator for a two-wheel stepper drive.
// ---------------------------------------------------------------------------
// Channels: req carries one beat per prescaled timer tick (req_type 0) or
// move start (req_type 1, with move_kind and amount). rsp returns exactly one
// beat per req beat, in order: step pulse, direction pins, driver wake,
// moved flag, ramp phase and current period. cfg writes the five registers
// (index 0 min_period .. 4 degree_scale) and is always ready; write it only
// while no request is in flight.
// Path: a req beat is taken into a stage register, and its result beat is
// loaded into the output register once that register is free or being read;
// rsp.valid then rises and holds until the result beat is taken.
// Throughput: one beat per cycle while rsp is not stalled. The stage holds
// all the work: the start multiply of amount by a 24-bit scale, or the timer
// compare, the step counter and the ramp update for a tick.
// Stall: while rsp is stalled the output beat holds; one more req beat is
// taken into the stage register, then req.ready drops until rsp moves.
// Reset: all registers but the stage and output payloads return to their
// reset values, the driver sleeps, the period is 120 and no beat is pending.
// ---------------------------------------------------------------------------
module stepper_trapezoid_ramp #(
	parameter int unsigned STEP_COUNT_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	str_req_if.sink   req,
	str_rsp_if.source rsp,
	str_cfg_if.sink   cfg
);

	str_pkg::cfg_t              cfg_cur;
	logic                       valid_s1;
	logic                       req_type_s1;
	logic [1:0]                 move_kind_s1;
	logic [str_pkg::AMOUNT_BITS-1:0] amount_s1;
	logic [STEP_COUNT_BITS-1:0] target;
	str_pkg::rsp_t              result;
	str_pkg::rsp_t              rsp_q;
	logic                       rsp_valid_q;
	logic                       out_free;
	logic                       fire;

	// handshake between stage and output register
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign fire      = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	str_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_cur)
	);

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1  <= req.req_type;
			move_kind_s1 <= req.move_kind;
			amount_s1    <= req.amount;
		end
	end

	str_target #(
		.STEP_COUNT_BITS (STEP_COUNT_BITS)
	) u_target (
		.move_kind (move_kind_s1),
		.amount    (amount_s1),
		.cfg       (cfg_cur),
		.target    (target)
	);

	str_core #(
		.STEP_COUNT_BITS (STEP_COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.req_type  (req_type_s1),
		.move_kind (move_kind_s1),
		.target_in (target),
		.cfg       (cfg_cur),
		.result    (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.step_strobe  = rsp_q.step_strobe;
	assign rsp.right_dir    = rsp_q.right_dir;
	assign rsp.left_dir     = rsp_q.left_dir;
	assign rsp.driver_awake = rsp_q.driver_awake;
	assign rsp.move_done    = rsp_q.move_done;
	assign rsp.ramp_phase   = rsp_q.ramp_phase;
	assign rsp.step_period  = rsp_q.step_period;

endmodule

@@ design/str_checker.sv @@
// ---------------------------------------------------------------------------
// str_checker
// Port-level checks of the ramp generator, bound to the top level.
// ---------------------------------------------------------------------------
module str_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       step_strobe,
	input logic       driver_awake,
	input logic       move_done,
	input logic [1:0] ramp_phase,
	input logic [7:0] step_period
);

	// a stalled result beat stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(step_period) && $stable(ramp_phase)
			&& $stable(step_strobe))
		else $error("result payload changed while stalled");

	// a finished move has put the driver to sleep
	a_done_sleeps: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && move_done |-> !driver_awake)
		else $error("moved flag set with driver awake");

	// steps come only from a running move, or from its last step
	a_pulse_running: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && step_strobe |-> driver_awake || move_done)
		else $error("step pulse without a running move");

	// leaving acceleration happens only inside a move
	a_phase_running: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ramp_phase != str_pkg::RAMP_ACCEL |-> driver_awake)
		else $error("ramp past acceleration with driver asleep");

endmodule

bind stepper_trapezoid_ramp str_checker u_str_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.step_strobe  (rsp.step_strobe),
	.driver_awake (rsp.driver_awake),
	.move_done    (rsp.move_done),
	.ramp_phase   (rsp.ramp_phase),
	.step_period  (rsp.step_period)
);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the trapezoidal step-rate ramp generator. A
// cycle-free model of the ramp tracks every accepted request beat and
// queues the status it should produce. Each result beat is checked field by
// field against the oldest queued status. The test sequence covers idle
// timer ticks, the reset registers, a long ramp down from the reset period,
// every move kind, a minimum above the maximum, a period below the minimum,
// zero spacing and register extremes. It ends with random moves under
// random settings, with random gaps on the request side and stalls on the
// result side.
// ---------------------------------------------------------------------------
module tb;

	localparam int unsigned CNT_BITS = 24;
	localparam logic [63:0] COUNT_LIMIT = (64'd1 << CNT_BITS) - 64'd1;

	logic clk = 1'b0;
	logic arst_n;

	str_req_if req_ch();
	str_rsp_if rsp_ch();
	str_cfg_if cfg_ch();

	stepper_trapezoid_ramp #(.STEP_COUNT_BITS(CNT_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies held by the ramp model
	logic [7:0]          min_per;
	logic [7:0]          max_per;
	logic [7:0]          spacing_lim;
	logic [23:0]         dist_scale;
	logic [23:0]         deg_scale;

	// motion state of the ramp model
	logic [CNT_BITS-1:0] step_cnt;
	logic [CNT_BITS-1:0] target_cnt;
	logic [7:0]          spacing_cnt;
	logic [1:0]          ramp_state;
	logic [7:0]          period_r;
	logic [7:0]          tick_r;
	logic                running_r;
	logic                done_r;
	logic [1:0]          dir_r;
	logic                awake_r;

	str_pkg::rsp_t pending_status[$];
	bit            idle_on;
	int unsigned   mismatch_count;
	int unsigned   items_sent;
	int unsigned   beats_checked;
	int unsigned   moves_finished;
	int unsigned   cfg_writes;

	// one step of the ramp: counters, then phase and period
	task automatic take_step();
		logic        change;
		logic [31:0] span;
		logic [31:0] ramp_len;
		logic [31:0] brake_point;
		step_cnt = step_cnt + CNT_BITS'(1);
		spacing_cnt = spacing_cnt + 8'd1;
		change = 1'b0;
		if (spacing_cnt >= spacing_lim) begin
			spacing_cnt = '0;
			change = 1'b1;
		end
		case (ramp_state)
			str_pkg::RAMP_ACCEL: begin
				if (change && period_r > min_per)
					period_r = period_r - 8'd1;
				else if (period_r <= min_per)
					ramp_state = str_pkg::RAMP_CONST;
			end
			str_pkg::RAMP_CONST: begin
				span = (max_per > min_per) ? 32'(max_per - min_per) : 32'd0;
				ramp_len = 32'(spacing_lim) * span;
				brake_point = (32'(target_cnt) > ramp_len) ?
					32'(target_cnt) - ramp_len : 32'd0;
				if (32'(step_cnt) >= brake_point)
					ramp_state = str_pkg::RAMP_DECEL;
			end
			str_pkg::RAMP_DECEL: begin
				if (change && period_r < max_per) begin
					period_r = period_r + 8'd1;
				end else if (period_r >= max_per) begin
					// move over: stop, sleep, clear and flag
					running_r = 1'b0;
					awake_r = 1'b0;
					step_cnt = '0;
					target_cnt = '0;
					spacing_cnt = '0;
					ramp_state = str_pkg::RAMP_ACCEL;
					done_r = 1'b1;
					moves_finished++;
				end
			end
			default: ;
		endcase
	endtask

	// advance the model by one request beat and queue its status beat
	task automatic predict_status(input logic rt, input logic [1:0] kind,
		input logic [15:0] amt);
		str_pkg::rsp_t beat;
		logic [63:0]   steps;
		logic [23:0]   scale;
		logic          pulse;
		pulse = 1'b0;
		if (rt == str_pkg::REQ_START) begin
			scale = (kind == str_pkg::KIND_FORWARD || kind == str_pkg::KIND_BACKWARD) ?
				dist_scale : deg_scale;
			steps = (64'(amt) * 64'(scale) + 64'd32768) >> str_pkg::FRAC_BITS;
			if (steps > COUNT_LIMIT)
				steps = COUNT_LIMIT;
			target_cnt = steps[CNT_BITS-1:0];
			done_r = 1'b0;
			awake_r = 1'b1;
			running_r = 1'b1;
			// bit 0 right pin, bit 1 left pin
			case (kind)
				str_pkg::KIND_FORWARD:  dir_r = 2'b00;
				str_pkg::KIND_BACKWARD: dir_r = 2'b11;
				str_pkg::KIND_LEFT:     dir_r = 2'b10;
				default:                dir_r = 2'b01;
			endcase
		end else if (tick_r >= period_r) begin
			// compare match
			tick_r = '0;
			if (running_r) begin
				pulse = 1'b1;
				take_step();
			end
		end else begin
			tick_r = tick_r + 8'd1;
		end
		beat.step_strobe = pulse;
		beat.right_dir = dir_r[0];
		beat.left_dir = dir_r[1];
		beat.driver_awake = awake_r;
		beat.move_done = done_r;
		beat.ramp_phase = ramp_state;
		beat.step_period = period_r;
		pending_status.push_back(beat);
	endtask

	task automatic reset_model();
		min_per = str_pkg::RST_MIN_PERIOD;
		max_per = str_pkg::RST_MAX_PERIOD;
		spacing_lim = str_pkg::RST_STEPS_PER_CHANGE;
		dist_scale = str_pkg::RST_DISTANCE_SCALE;
		deg_scale = str_pkg::RST_DEGREE_SCALE;
		step_cnt = '0;
		target_cnt = '0;
		spacing_cnt = '0;
		ramp_state = str_pkg::RAMP_ACCEL;
		period_r = 8'd120;
		tick_r = '0;
		running_r = 1'b0;
		done_r = 1'b0;
		dir_r = 2'b00;
		awake_r = 1'b0;
	endtask

	// one request beat, with a random gap ahead of it when idling is on
	task automatic send_item(input logic rt, input logic [1:0] kind,
		input logic [15:0] amt);
		int unsigned gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 7) == 0)
			gap = $urandom_range(1, 17);
		@(negedge clk);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.move_kind <= kind;
		req_ch.amount <= amt;
		do @(posedge clk); while (!req_ch.ready);
		predict_status(rt, kind, amt);
		items_sent++;
	endtask

	// tick payload bits are don't-care, so they are randomized
	task automatic send_tick();
		send_item(str_pkg::REQ_TICK, 2'($urandom_range(0, 3)), 16'($urandom));
	endtask

	task automatic send_start(input logic [1:0] kind, input logic [15:0] amt);
		send_item(str_pkg::REQ_START, kind, amt);
	endtask

	task automatic run_until_stopped(input int unsigned cap);
		int unsigned n;
		n = 0;
		while (running_r && n < cap) begin
			send_tick();
			n++;
		end
	endtask

	// stop requests and wait for every status beat to come back
	task automatic quiesce();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			str_pkg::REG_MIN_PERIOD:       min_per = value[7:0];
			str_pkg::REG_MAX_PERIOD:       max_per = value[7:0];
			str_pkg::REG_STEPS_PER_CHANGE: spacing_lim = value[7:0];
			str_pkg::REG_DISTANCE_SCALE:   dist_scale = value;
			str_pkg::REG_DEGREE_SCALE:     deg_scale = value;
			default: ;
		endcase
		cfg_writes++;
	endtask

	// all five registers, written with no request in flight
	task automatic set_config(input logic [7:0] min_v, input logic [7:0] max_v,
		input logic [7:0] spc_v, input logic [23:0] dist_v,
		input logic [23:0] deg_v);
		quiesce();
		write_reg(str_pkg::REG_MIN_PERIOD, 24'(min_v));
		write_reg(str_pkg::REG_MAX_PERIOD, 24'(max_v));
		write_reg(str_pkg::REG_STEPS_PER_CHANGE, 24'(spc_v));
		write_reg(str_pkg::REG_DISTANCE_SCALE, dist_v);
		write_reg(str_pkg::REG_DEGREE_SCALE, deg_v);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// timer runs with no move: no pulses, driver asleep
	task automatic test_idle_timer();
		repeat (4) send_tick();
	endtask

	// a move under the reset registers, long enough for a few pulses
	task automatic test_default_registers();
		send_start(str_pkg::KIND_BACKWARD, 16'd1);
		repeat (300) send_tick();
	endtask

	// full ramp down from the reset period to a fast setting
	task automatic test_warmup_ramp();
		set_config(8'd1, 8'd3, 8'd1, 24'h010000, 24'h008000);
		run_until_stopped(20000);
	endtask

	// every kind, zero and full amounts, rounding on a half-step scale
	task automatic test_move_kinds();
		set_config(8'd1, 8'd3, 8'd1, 24'h018000, 24'h008000);
		send_start(str_pkg::KIND_FORWARD, 16'd0);
		repeat (2) send_tick();
		send_start(str_pkg::KIND_BACKWARD, 16'hFFFF);
		send_tick();
		send_start(str_pkg::KIND_LEFT, 16'd1);
		send_tick();
		send_start(str_pkg::KIND_RIGHT, 16'hFFFF);
		send_tick();
		send_start(str_pkg::KIND_RIGHT, 16'd3);
		run_until_stopped(5000);
	endtask

	// no ramp when min exceeds max; period already above max at the end
	task automatic test_min_above_max();
		set_config(8'd5, 8'd2, 8'd2, 24'h010000, 24'h010000);
		send_start(str_pkg::KIND_FORWARD, 16'd4);
		run_until_stopped(5000);
	endtask

	// period below the new minimum goes straight to constant speed
	task automatic test_below_min();
		set_config(8'd6, 8'd9, 8'd1, 24'h010000, 24'h010000);
		send_start(str_pkg::KIND_FORWARD, 16'd8);
		run_until_stopped(5000);
	endtask

	// zero spacing changes the period on every step
	task automatic test_zero_spacing();
		set_config(8'd1, 8'd4, 8'd0, 24'h010000, 24'h010000);
		send_start(str_pkg::KIND_LEFT, 16'd10);
		repeat (20) send_tick();
		send_start(str_pkg::KIND_BACKWARD, 16'd2);
		run_until_stopped(5000);
	endtask

	// largest and zero register values, then back to a fast setting
	task automatic test_config_extremes();
		set_config(8'd255, 8'd255, 8'd255, 24'hFFFFFF, 24'hFFFFFF);
		send_start(str_pkg::KIND_FORWARD, 16'hFFFF);
		repeat (3) send_tick();
		send_start(str_pkg::KIND_LEFT, 16'hFFFF);
		repeat (3) send_tick();
		set_config(8'd255, 8'd255, 8'd255, 24'h000000, 24'h000000);
		send_start(str_pkg::KIND_BACKWARD, 16'hFFFF);
		repeat (3) send_tick();
		set_config(8'd1, 8'd4, 8'd2, 24'h010000, 24'h010000);
		run_until_stopped(5000);
	endtask

	// one move: mostly small and well formed, some oversized, retargeted
	// or abandoned halfway
	task automatic random_move();
		logic [1:0]  kind;
		int unsigned guard;
		int unsigned r;
		kind = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0) begin
			send_start(kind, 16'($urandom));
			repeat ($urandom_range(0, 60)) send_tick();
		end
		send_start(kind, 16'($urandom_range(0, 6)));
		guard = 0;
		while (running_r && guard < 3000) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				send_start(2'($urandom_range(0, 3)), 16'($urandom_range(0, 6)));
			else if (r < 3)
				break;
			else
				send_tick();
			guard++;
		end
		repeat ($urandom_range(0, 4)) send_tick();
	endtask

	// random settings per phase, last phase with no idling
	task automatic test_random_moves();
		int unsigned phase_idx;
		int unsigned phase_start;
		for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
			set_config(8'($urandom_range(1, 4)), 8'($urandom_range(1, 7)),
				8'($urandom_range(0, 3)), 24'($urandom_range(24'h4000, 24'h20000)),
				24'($urandom_range(24'h4000, 24'h20000)));
			idle_on = (phase_idx != 3);
			phase_start = items_sent;
			while (items_sent - phase_start < 300)
				random_move();
		end
	endtask

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// status beat checker
	always @(posedge clk) begin
		str_pkg::rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_status.size() == 0) begin
				$error("status beat with no request waiting");
				mismatch_count++;
			end else begin
				want = pending_status.pop_front();
				check_field("step_strobe", want.step_strobe, rsp_ch.step_strobe);
				check_field("right_dir", want.right_dir, rsp_ch.right_dir);
				check_field("left_dir", want.left_dir, rsp_ch.left_dir);
				check_field("driver_awake", want.driver_awake, rsp_ch.driver_awake);
				check_field("move_done", want.move_done, rsp_ch.move_done);
				check_field("ramp_phase", want.ramp_phase, rsp_ch.ramp_phase);
				check_field("step_period", want.step_period, rsp_ch.step_period);
				beats_checked++;
			end
		end
	end

	// result side stalls in random bursts
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 17);
			if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		#(64'd20_000_000);
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = str_pkg::REQ_TICK;
		req_ch.move_kind = str_pkg::KIND_FORWARD;
		req_ch.amount = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = str_pkg::REG_MIN_PERIOD;
		cfg_ch.data = '0;
		idle_on = 1'b1;
		mismatch_count = 0;
		items_sent = 0;
		beats_checked = 0;
		moves_finished = 0;
		cfg_writes = 0;
		reset_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_timer();
		test_default_registers();
		test_warmup_ramp();
		test_move_kinds();
		test_min_above_max();
		test_below_min();
		test_zero_spacing();
		test_config_extremes();
		test_random_moves();
		quiesce();

		$display("run covered %0d request beats, %0d status beats checked",
			items_sent, beats_checked);
		$display("%0d moves ran to the end, %0d register writes, %0d mismatches",
			moves_finished, cfg_writes, mismatch_count);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
design/str_pkg.sv
design/str_req_if.sv
design/str_rsp_if.sv
design/str_cfg_if.sv
design/str_cfg_regs.sv
design/str_target.sv
design/str_core.sv
design/stepper_trapezoid_ramp.sv
design/str_checker.sv
test/tb.sv
